// File: hdl/pbd_pkg.sv
package pbd_pkg;

	// Field and register widths.
	localparam int SampleW  = 12;
	localparam int FracW    = 4;
	localparam int LevelW   = SampleW + FracW;
	localparam int PeriodW  = 7;
	localparam int CountW   = 12;
	localparam int NW       = CountW + PeriodW;
	localparam int IntW     = 12;
	localparam int BpmW     = 8;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 12;

	// Interval ring.
	localparam int RingDepth = 10;
	localparam int RingIdxW  = $clog2(RingDepth);
	localparam int FillW     = $clog2(RingDepth + 1);
	localparam int SumW      = $clog2(RingDepth * (1 << IntW));

	// Average of the ring: sum times a rounded-up reciprocal of the depth.
	localparam int AvgW      = IntW;
	localparam int AvgShift  = SumW + $clog2(RingDepth);
	localparam int AvgRecipW = SumW + 2;
	localparam logic [AvgRecipW-1:0] AvgRecip =
		AvgRecipW'(((1 << AvgShift) + RingDepth - 1) / RingDepth);
	localparam int ProdW     = SumW + AvgRecipW;

	// Beats per minute: constant dividend over the average interval.
	localparam int QuotW = 16;
	localparam logic [QuotW-1:0] BpmNum = 16'd60000;
	localparam int DivCntW = $clog2(QuotW);

	// Division by five of the last interval, exact for 12-bit values.
	localparam int Div5ProdW = 24;
	localparam logic [Div5ProdW-1:0] Div5Recip = 24'd3277;
	localparam int Div5Shift = 14;
	localparam int Div5W     = 10;

	// Timing constants in milliseconds and reset values.
	localparam logic [NW-1:0]       BeatMinMs       = 19'd250;
	localparam logic [NW-1:0]       TimeoutMs       = 19'd2500;
	localparam logic [IntW-1:0]     IntervalReset   = 12'd600;
	localparam logic [PeriodW-1:0]  PeriodReset     = 7'd2;
	localparam logic [SampleW-1:0]  ThrDefaultReset = 12'd2048;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CfgSamplePeriod     = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgThresholdDefault = 2'd1;

	typedef struct packed {
		logic            start;
		logic            seed;
		logic [IntW-1:0] interval;
	} ring_cmd_t;

	typedef struct packed {
		logic            done;
		logic [SumW-1:0] sum;
	} ring_sts_t;

	typedef struct packed {
		logic            start;
		logic [SumW-1:0] sum;
	} rate_cmd_t;

	typedef struct packed {
		logic            done;
		logic [BpmW-1:0] bpm;
	} rate_sts_t;

endpackage

// File: hdl/pbd_ring.sv
module pbd_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  pbd_pkg::ring_cmd_t cmd,
	output pbd_pkg::ring_sts_t sts
);
	import pbd_pkg::*;

	typedef enum logic [1:0] {R_IDLE, R_UPD, R_DONE} ring_state_t;

	ring_state_t          state_q;
	logic [IntW-1:0]      ring_mem_q [RingDepth];
	logic [IntW-1:0]      rd_q;
	logic [IntW-1:0]      intv_q;
	logic [IntW-1:0]      seed_q;
	logic [RingIdxW-1:0]  head_q;
	logic [FillW-1:0]     fill_q;
	logic [SumW-1:0]      sum_q;
	logic                 rd_en;
	logic                 wr_en;
	logic [IntW-1:0]      oldest;

	// Read the oldest entry when a plain update starts; overwrite it with the new interval in the next cycle.
	assign rd_en = (state_q == R_IDLE) && cmd.start && !cmd.seed;
	assign wr_en = (state_q == R_UPD);

	// Entries not yet rewritten since seeding all hold the seed interval.
	assign oldest = (fill_q == FillW'(RingDepth)) ? rd_q : seed_q;

	// Ring storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem_q[head_q] <= intv_q;
		end
		if (rd_en) begin
			rd_q <= ring_mem_q[head_q];
		end
	end

	// Running sum, write pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					if (cmd.start) begin
						intv_q <= cmd.interval;
						if (cmd.seed) begin
							seed_q  <= cmd.interval;
							head_q  <= '0;
							fill_q  <= '0;
							sum_q   <= SumW'(cmd.interval) * SumW'(RingDepth);
							state_q <= R_DONE;
						end else begin
							state_q <= R_UPD;
						end
					end
				end
				R_UPD: begin
					sum_q   <= sum_q - SumW'(oldest) + SumW'(intv_q);
					head_q  <= (head_q == RingIdxW'(RingDepth - 1)) ? '0 : head_q + 1'b1;
					if (fill_q != FillW'(RingDepth)) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= R_DONE;
				end
				R_DONE: begin
					state_q <= R_IDLE;
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	assign sts.done = (state_q == R_DONE);
	assign sts.sum  = sum_q;

endmodule

// File: hdl/pbd_rate.sv
module pbd_rate (
	input  logic               clk,
	input  logic               arst_n,
	input  pbd_pkg::rate_cmd_t cmd,
	output pbd_pkg::rate_sts_t sts
);
	import pbd_pkg::*;

	typedef enum logic [1:0] {RT_IDLE, RT_AVG, RT_DIV, RT_DONE} rate_state_t;

	rate_state_t         state_q;
	logic [ProdW-1:0]    prod_q;
	logic [AvgW-1:0]     avg_q;
	logic [AvgW-1:0]     rem_q;
	logic [QuotW-1:0]    dvd_q;
	logic [DivCntW-1:0]  cnt_q;
	logic [AvgW:0]       rem_sh;
	logic                qbit;
	logic [AvgW:0]       rem_diff;

	// One restoring step: shift in the next dividend bit and try the subtraction.
	assign rem_sh   = {rem_q, dvd_q[QuotW-1]};
	assign qbit     = (rem_sh >= {1'b0, avg_q});
	assign rem_diff = rem_sh - {1'b0, avg_q};

	// Average by reciprocal multiply, then sixteen divide steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RT_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				RT_IDLE: begin
					if (cmd.start) begin
						prod_q  <= ProdW'(cmd.sum) * ProdW'(AvgRecip);
						state_q <= RT_AVG;
					end
				end
				RT_AVG: begin
					avg_q   <= prod_q[AvgShift +: AvgW];
					rem_q   <= '0;
					dvd_q   <= BpmNum;
					cnt_q   <= '0;
					state_q <= RT_DIV;
				end
				RT_DIV: begin
					rem_q <= qbit ? rem_diff[AvgW-1:0] : rem_sh[AvgW-1:0];
					dvd_q <= {dvd_q[QuotW-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DivCntW'(QuotW - 1)) begin
						state_q <= RT_DONE;
					end
				end
				RT_DONE: begin
					state_q <= RT_IDLE;
				end
				default: begin
					state_q <= RT_IDLE;
				end
			endcase
		end
	end

	// A zero average yields an all-ones quotient and so saturates as well.
	assign sts.done = (state_q == RT_DONE);
	assign sts.bpm  = (|dvd_q[QuotW-1:BpmW]) ? {BpmW{1'b1}} : dvd_q[BpmW-1:0];

endmodule

// File: hdl/pulse_beat_detector_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     sample
// out       output     out_valid / out_ready   bpm, interval_ms, beat, pulse_active
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample at a time: each sample passes ST_MUL, ST_EVAL and ST_OUT, and a beat that
// seeds or updates the ring also waits in ST_RING and ST_RATE;
// the 16-step restoring divider in pbd_rate sets the long case.
// Reset returns levels, flags and counters to their defaults; the ring is not cleared.
// A finished reading waits in the output register while the next sample is taken;
// the block stalls only when a new result is ready and the old one is not taken.
module pulse_beat_detector_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pbd_pkg::SampleW-1:0]    sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pbd_pkg::BpmW-1:0]       bpm,
	output logic [pbd_pkg::IntW-1:0]       interval_ms,
	output logic                           beat,
	output logic                           pulse_active,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pbd_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [pbd_pkg::CfgDataW-1:0]   cfg_data
);
	import pbd_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_EVAL, ST_RING, ST_RATE, ST_OUT} state_t;

	state_t               state_q;
	logic [PeriodW-1:0]   period_q;
	logic [SampleW-1:0]   thrdef_q;
	logic [SampleW-1:0]   sample_q;
	logic [CountW-1:0]    count_q;
	logic [IntW-1:0]      last_q;
	logic [LevelW-1:0]    peak_q;
	logic [LevelW-1:0]    trough_q;
	logic [LevelW-1:0]    thr_q;
	logic                 in_pulse_q;
	logic                 first_q;
	logic                 second_q;
	logic [BpmW-1:0]      bpm_q;
	logic [NW-1:0]        n_q;
	logic [Div5W-1:0]     div5_q;
	logic                 beat_q;
	logic                 ring_start_q;
	logic                 ring_seed_q;
	logic                 rate_start_q;
	logic                 out_valid_q;
	logic [BpmW-1:0]      out_bpm_q;
	logic [IntW-1:0]      out_interval_q;
	logic                 out_beat_q;
	logic                 out_pulse_q;

	logic [Div5ProdW-1:0] div5_prod;
	logic [LevelW-1:0]    s;
	logic [LevelW-1:0]    lvl_def;
	logic [IntW-1:0]      guard;
	logic                 n_gt_guard;
	logic                 lo;
	logic                 hi;
	logic [LevelW-1:0]    trough_n;
	logic [LevelW-1:0]    peak_n;
	logic                 beat_c;
	logic                 skip_end;
	logic                 timeout_c;
	logic                 end_pulse;
	logic [LevelW-1:0]    amp;
	logic [LevelW-1:0]    thr_mid;
	logic                 out_load;

	ring_cmd_t            ring_cmd;
	ring_sts_t            ring_sts;
	rate_cmd_t            rate_cmd;
	rate_sts_t            rate_sts;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// The output register takes a new reading when it is empty or being emptied.
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign div5_prod = Div5ProdW'(last_q) * Div5Recip;

	// Per-sample decision on the registered elapsed time and guard interval.
	always_comb begin
		s          = {sample_q, {FracW{1'b0}}};
		lvl_def    = {thrdef_q, {FracW{1'b0}}};
		guard      = IntW'({div5_q, 1'b0}) + IntW'(div5_q);
		n_gt_guard = (n_q > NW'(guard));
		lo         = (s < thr_q);
		hi         = (s > thr_q);
		trough_n   = (lo && n_gt_guard && (s < trough_q)) ? s : trough_q;
		peak_n     = (hi && (s > peak_q)) ? s : peak_q;
		beat_c     = (n_q > BeatMinMs) && hi && !in_pulse_q && n_gt_guard;
		// The discarded first beat ends the step before pulse end and timeout.
		skip_end   = beat_c && first_q;
		timeout_c  = (n_q > TimeoutMs) && !skip_end;
		end_pulse  = lo && in_pulse_q && !skip_end;
		amp        = (peak_n >= trough_n) ? peak_n - trough_n : '0;
		thr_mid    = trough_n + (amp >> 1);
	end

	// Control, levels, configuration and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			period_q     <= PeriodReset;
			thrdef_q     <= ThrDefaultReset;
			count_q      <= '0;
			last_q       <= IntervalReset;
			peak_q       <= {ThrDefaultReset, {FracW{1'b0}}};
			trough_q     <= {ThrDefaultReset, {FracW{1'b0}}};
			thr_q        <= {ThrDefaultReset, {FracW{1'b0}}};
			in_pulse_q   <= 1'b0;
			first_q      <= 1'b1;
			second_q     <= 1'b0;
			bpm_q        <= '0;
			ring_start_q <= 1'b0;
			rate_start_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// One-cycle start pulses for the ring and the divider.
			ring_start_q <= (state_q == ST_EVAL) && beat_c && !first_q && !timeout_c;
			rate_start_q <= (state_q == ST_RING) && ring_sts.done;

			// Output valid rises on a load and falls once the reading is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// The user must write registers only while no sample is in flight; the block does not enforce it.
			if (cfg_valid) begin
				unique case (cfg_index)
					CfgSamplePeriod:     period_q <= cfg_data[PeriodW-1:0];
					CfgThresholdDefault: thrdef_q <= cfg_data[SampleW-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_q <= sample;
						count_q  <= count_q + CountW'(1);
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					n_q     <= NW'(count_q) * NW'(period_q);
					div5_q  <= div5_prod[Div5Shift +: Div5W];
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					beat_q <= beat_c;
					if (timeout_c) begin
						thr_q      <= lvl_def;
						peak_q     <= lvl_def;
						trough_q   <= lvl_def;
						count_q    <= '0;
						first_q    <= 1'b1;
						second_q   <= 1'b0;
						bpm_q      <= '0;
						last_q     <= IntervalReset;
						in_pulse_q <= 1'b0;
						state_q    <= ST_OUT;
					end else begin
						peak_q   <= end_pulse ? thr_mid : peak_n;
						trough_q <= end_pulse ? thr_mid : trough_n;
						if (end_pulse) begin
							thr_q      <= thr_mid;
							in_pulse_q <= 1'b0;
						end
						if (beat_c) begin
							in_pulse_q <= 1'b1;
							last_q     <= n_q[IntW-1:0];
							count_q    <= '0;
							first_q    <= 1'b0;
							second_q   <= first_q;
						end
						if (beat_c && !first_q) begin
							ring_seed_q <= second_q;
							state_q     <= ST_RING;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_RING: begin
					if (ring_sts.done) begin
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					if (rate_sts.done) begin
						bpm_q   <= rate_sts.bpm;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_bpm_q      <= bpm_q;
						out_interval_q <= last_q;
						out_beat_q     <= beat_q;
						out_pulse_q    <= in_pulse_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ring_cmd.start    = ring_start_q;
	assign ring_cmd.seed     = ring_seed_q;
	assign ring_cmd.interval = last_q;

	assign rate_cmd.start = rate_start_q;
	assign rate_cmd.sum   = ring_sts.sum;

	pbd_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ring_cmd),
		.sts    (ring_sts)
	);

	pbd_rate u_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rate_cmd),
		.sts    (rate_sts)
	);

	assign out_valid    = out_valid_q;
	assign bpm          = out_bpm_q;
	assign interval_ms  = out_interval_q;
	assign beat         = out_beat_q;
	assign pulse_active = out_pulse_q;

	// Before the first beat no rate is known and the ring is not armed.
	a_first_no_rate: assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> (bpm_q == '0 && !second_q))
		else $error("rate or ring armed before the first beat");

	// A ring update runs only once both beat flags are spent.
	a_ring_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RING) |-> (!first_q && !second_q))
		else $error("ring update with first or second beat pending");

	// The ring completes only while the sequencer waits for it.
	a_ring_done: assert property (@(posedge clk) disable iff (!arst_n)
		ring_sts.done |-> (state_q == ST_RING))
		else $error("ring completion outside ring wait");

	// The divider completes only while the sequencer waits for it.
	a_rate_done: assert property (@(posedge clk) disable iff (!arst_n)
		rate_sts.done |-> (state_q == ST_RATE))
		else $error("rate completion outside rate wait");

endmodule

// File: dv/tb_pulse_beat_detector_unit.sv
// One reading of the detector as it leaves the output channel.
typedef struct packed {
	logic [pbd_pkg::BpmW-1:0] bpm;
	logic [pbd_pkg::IntW-1:0] interval_ms;
	logic                     beat;
	logic                     pulse_active;
} reading_t;

// Tracks the detector's levels, flags and interval ring, and holds the readings still owed.
class heartbeat_tracker;
	logic [pbd_pkg::PeriodW-1:0] period;
	logic [pbd_pkg::SampleW-1:0] thr_default;
	logic [pbd_pkg::CountW-1:0]  count;
	logic [pbd_pkg::IntW-1:0]    last_int;
	logic [pbd_pkg::LevelW-1:0]  peak;
	logic [pbd_pkg::LevelW-1:0]  trough;
	logic [pbd_pkg::LevelW-1:0]  thr_level;
	bit                          in_pulse;
	bit                          first_pending;
	bit                          second_pending;
	logic [pbd_pkg::IntW-1:0]    ring [pbd_pkg::RingDepth];
	int unsigned                 ring_sum;
	logic [pbd_pkg::BpmW-1:0]    bpm_val;
	reading_t                    pending_readings [$];
	int                          errors;

	function new();
		period      = pbd_pkg::PeriodReset;
		thr_default = pbd_pkg::ThrDefaultReset;
		ring_sum    = 0;
		errors      = 0;
		foreach (ring[i]) ring[i] = '0;
		restore_defaults();
	endfunction

	// Levels and flags after reset or after a long stretch without a beat.
	function void restore_defaults();
		thr_level      = {thr_default, 4'b0000};
		peak           = thr_level;
		trough         = thr_level;
		count          = '0;
		first_pending  = 1'b1;
		second_pending = 1'b0;
		bpm_val        = '0;
		last_int       = pbd_pkg::IntervalReset;
		in_pulse       = 1'b0;
	endfunction

	function void write_reg(logic [pbd_pkg::CfgIdxW-1:0] idx, logic [pbd_pkg::CfgDataW-1:0] data);
		if (idx == pbd_pkg::CfgSamplePeriod)
			period = data[pbd_pkg::PeriodW-1:0];
		else if (idx == pbd_pkg::CfgThresholdDefault)
			thr_default = data[pbd_pkg::SampleW-1:0];
	endfunction

	// Advance the detector by one accepted sample and queue the reading it produces.
	function void note_sample(logic [pbd_pkg::SampleW-1:0] raw);
		logic [pbd_pkg::LevelW-1:0] s;
		logic [pbd_pkg::LevelW-1:0] amp;
		int unsigned                n;
		int unsigned                guard;
		int unsigned                avg;
		int unsigned                quot;
		bit                         hit;
		bit                         armed_only;
		reading_t                   r;
		s          = {raw, 4'b0000};
		hit        = 1'b0;
		armed_only = 1'b0;
		count      = count + 1'b1;
		n          = int'(count) * int'(period);
		guard      = (int'(last_int) / 5) * 3;

		if (s < thr_level && n > guard && s < trough)
			trough = s;
		if (s > thr_level && s > peak)
			peak = s;

		// Rising edge through the threshold, outside the refractory window.
		if (n > pbd_pkg::BeatMinMs && s > thr_level && !in_pulse && n > guard) begin
			hit      = 1'b1;
			in_pulse = 1'b1;
			last_int = n[pbd_pkg::IntW-1:0];
			count    = '0;
			if (second_pending) begin
				second_pending = 1'b0;
				foreach (ring[i]) ring[i] = last_int;
			end
			if (first_pending) begin
				first_pending  = 1'b0;
				second_pending = 1'b1;
				armed_only     = 1'b1;
			end else begin
				ring_sum = 0;
				for (int i = 0; i + 1 < pbd_pkg::RingDepth; i++) begin
					ring[i]  = ring[i+1];
					ring_sum += ring[i];
				end
				ring[pbd_pkg::RingDepth-1] = last_int;
				ring_sum += last_int;
				avg = ring_sum / pbd_pkg::RingDepth;
				if (avg == 0) begin
					bpm_val = 8'd255;
				end else begin
					quot    = pbd_pkg::BpmNum / avg;
					bpm_val = (quot > 255) ? 8'd255 : quot[7:0];
				end
			end
		end

		// Pulse end re-centers the threshold; the timeout falls back to defaults.
		if (!armed_only) begin
			if (s < thr_level && in_pulse) begin
				amp       = (peak >= trough) ? peak - trough : '0;
				in_pulse  = 1'b0;
				thr_level = trough + (amp >> 1);
				peak      = thr_level;
				trough    = thr_level;
			end
			if (n > pbd_pkg::TimeoutMs)
				restore_defaults();
		end

		r.bpm          = bpm_val;
		r.interval_ms  = last_int;
		r.beat         = hit;
		r.pulse_active = in_pulse;
		pending_readings.push_back(r);
	endfunction

	function void compare_field(string name, int unsigned want, logic [15:0] got);
		if (got !== 16'(want)) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Match one accepted reading against the oldest one still owed.
	function void check_reading(reading_t got);
		reading_t want;
		if (pending_readings.size() == 0) begin
			$display("%0t: unexpected reading, expected none, got bpm %0d interval %0d",
				$time, got.bpm, got.interval_ms);
			errors++;
			return;
		end
		want = pending_readings.pop_front();
		compare_field("bpm", want.bpm, 16'(got.bpm));
		compare_field("interval_ms", want.interval_ms, 16'(got.interval_ms));
		compare_field("beat", want.beat, 16'(got.beat));
		compare_field("pulse_active", want.pulse_active, 16'(got.pulse_active));
	endfunction
endclass

module tb_pulse_beat_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pbd_pkg::*;

	localparam int StallLimit   = 2000;
	localparam int HoldCycles   = 300;
	localparam int SettleCycles = 40;
	localparam int PhaseCount   = 12;
	localparam int RandomItems  = 1700;
	localparam logic [CfgIdxW-1:0] CfgSpareIndex = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SampleW-1:0]  sample;
	logic                out_valid;
	logic                out_ready;
	logic [BpmW-1:0]     bpm;
	logic [IntW-1:0]     interval_ms;
	logic                beat;
	logic                pulse_active;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	heartbeat_tracker board;
	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	int phase_items;
	int phase_target;

	pulse_beat_detector_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bpm          (bpm),
		.interval_ms  (interval_ms),
		.beat         (beat),
		.pulse_active (pulse_active),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ends the run when no channel moves a beat for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat on any channel for %0d cycles", $time, StallLimit);
		$display("FAIL pulse_beat_detector_unit");
		$finish;
	end

	// Output side: check accepted readings, stall at random, and hold off on request.
	initial begin
		int hold_left;
		reading_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {bpm, interval_ms, beat, pulse_active};
				board.check_reading(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HoldCycles;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < 26);
			end
		end
	end

	function automatic logic [SampleW-1:0] clip_code(int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return 12'hFFF;
		return v[SampleW-1:0];
	endfunction

	// Offer one sample and wait for its beat; valid stays up into the next call.
	task automatic offer_sample(input logic [SampleW-1:0] v);
		while (idle_on && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_sample(v);
		phase_items++;
	endtask

	// Write one register; the caller lowers cfg_valid after its last write.
	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// Stop offering and let every owed reading come out before touching registers.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_readings.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// A regular pulse train around the current threshold, with noise and jitter.
	// It stops early once the phase has sent its share of samples.
	task automatic play_rhythm(input int beats);
		int ms, spacing, width, len, center, lo, hi, nz, lvl;
		center = int'(board.thr_level[LevelW-1:FracW]);
		lo     = center - int'($urandom_range(100, 1500));
		hi     = center + int'($urandom_range(100, 1500));
		nz     = $urandom_range(0, 60);
		ms     = $urandom_range(260, (board.period < 5) ? 300 : 1800);
		if (board.period == 0)
			spacing = $urandom_range(20, 60);
		else
			spacing = ms / int'(board.period);
		if (spacing < 2)
			spacing = 2;
		for (int j = 0; j < beats; j++) begin
			len   = spacing + int'($urandom_range(0, spacing / 4 + 1)) - spacing / 8;
			width = $urandom_range(1, (len > 4) ? 4 : 1);
			for (int k = 0; k < len && phase_items < phase_target; k++) begin
				lvl = (k < width) ? hi : lo;
				offer_sample(clip_code(lvl + int'($urandom_range(0, 2 * nz)) - nz));
			end
		end
	endtask

	task automatic apply_setting(input logic [PeriodW-1:0] per, input logic [SampleW-1:0] thr);
		logic [4:0] junk;
		junk = 5'($urandom_range(0, 31));
		put_reg(CfgSamplePeriod, {junk, per});
		put_reg(CfgThresholdDefault, thr);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int r, flat, center;
		logic [PeriodW-1:0] per;
		logic [SampleW-1:0] thr;
		board     = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		sample    = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the longest period, a discarded first beat, then a beat that meets the timeout.
		put_reg(CfgSpareIndex, 12'hFFF);
		put_reg(CfgSamplePeriod, 12'd127);
		cfg_valid <= 1'b0;
		offer_sample(12'hFFF);
		offer_sample(12'h000);
		offer_sample(12'hFFF);
		repeat (19) offer_sample(12'h000);
		offer_sample(12'hFFF);
		drain();

		// Directed: a zero period never lets time pass.
		put_reg(CfgSamplePeriod, 12'd0);
		cfg_valid <= 1'b0;
		offer_sample(12'hFFF);
		offer_sample(12'h000);
		drain();

		// Random phases, each with its own setting.
		for (int ph = 0; ph < PhaseCount; ph++) begin
			r = $urandom_range(99);
			case (ph)
				0: per = 7'd1;
				1: per = 7'd127;
				2: per = 7'd100;
				default: begin
					if (r < 70)
						per = 7'($urandom_range(5, 40));
					else if (r < 85)
						per = 7'($urandom_range(41, 127));
					else
						per = 7'($urandom_range(0, 4));
				end
			endcase
			r = $urandom_range(99);
			case (ph)
				3: thr = 12'd0;
				4: thr = 12'hFFF;
				5: thr = 12'd1;
				default: thr = (r < 75) ? 12'($urandom_range(1200, 2900)) : 12'($urandom_range(0, 4095));
			endcase
			apply_setting(per, thr);
			idle_on = !(ph == 7 || ph == 8);
			if (ph == 6)
				hold_req = 1'b1;
			phase_items  = 0;
			phase_target = (ph == 4) ? 40 : RandomItems / PhaseCount;
			while (phase_items < phase_target) begin
				r = $urandom_range(99);
				if (r < 70) begin
					play_rhythm((board.period < 3) ? 1 : $urandom_range(2, 6));
				end else if (r < 85) begin
					// Long quiet run below threshold, often long enough to time out.
					flat   = (board.period == 0) ? 40 : 3000 / int'(board.period);
					flat   = $urandom_range(5, (flat > 150) ? 150 : flat);
					center = int'(board.thr_level[LevelW-1:FracW]) - int'($urandom_range(50, 800));
					for (int k = 0; k < flat && phase_items < phase_target; k++)
						offer_sample(clip_code(center));
				end else begin
					repeat ($urandom_range(5, 20)) offer_sample(12'($urandom_range(0, 4095)));
				end
			end
			drain();
		end

		idle_on = 1'b1;
		repeat (SettleCycles) @(posedge clk);
		if (board.pending_readings.size() != 0) begin
			$display("%0t: %0d readings expected, got none", $time, board.pending_readings.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("PASS pulse_beat_detector_unit");
		else
			$display("FAIL pulse_beat_detector_unit");
		$finish;
	end

endmodule

// File: pulse_beat_detector_unit.f
hdl/pbd_pkg.sv
hdl/pbd_ring.sv
hdl/pbd_rate.sv
hdl/pulse_beat_detector_unit.sv
dv/tb_pulse_beat_detector_unit.sv
